FILE: hdl/assert_macros.svh
// Assertion macros used by the f1 MAC top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition implies a property in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

FILE: hdl/milf1_pkg.sv
// Package with the AES tables, round functions and sequencer states of the f1 MAC.
`timescale 1ns / 1ps
`default_nettype none
package milf1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_OPC,
    PH_TEMP,
    PH_OUT
  } phase_e;

  localparam logic [127:0] OpConst = 128'h63bfa50ee6523365ff14c1f45f88737d;
  localparam logic [3:0] LastRound = 4'd10;

  localparam logic [7:0] Sbox [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 127-8i down to 120-8i.
  function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
    blk_byte = b[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [127:0] n;
    logic [31:0] t;
    t = {Sbox[blk_byte(k, 13)] ^ rc, Sbox[blk_byte(k, 14)],
         Sbox[blk_byte(k, 15)], Sbox[blk_byte(k, 12)]};
    n[127:96] = k[127:96] ^ t;
    n[95:64] = k[95:64] ^ n[127:96];
    n[63:32] = k[63:32] ^ n[95:64];
    n[31:0] = k[31:0] ^ n[63:32];
    next_key = n;
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c * 4 + i] = Sbox[blk_byte(s, ((c + i) % 4) * 4 + i)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c * 4];
      a1 = t[c * 4 + 1];
      a2 = t[c * 4 + 2];
      a3 = t[c * 4 + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        t[c * 4] = a0 ^ al ^ gf_double(a0 ^ a1);
        t[c * 4 + 1] = a1 ^ al ^ gf_double(a1 ^ a2);
        t[c * 4 + 2] = a2 ^ al ^ gf_double(a2 ^ a3);
        t[c * 4 + 3] = a3 ^ al ^ gf_double(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = t[i];
    end
    aes_round = r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/aes128_milenage_f1_mac.sv
// Top level of the f1 MAC: APB key registers, a shared AES round unit and its sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// An item is taken when start is high and busy is low. It runs three AES-128
// encryptions on one shared round unit with on-the-fly key expansion, one round
// per cycle, with a load state before and a hand-off state after each
// encryption. done_o rises as the last hand-off ends and stays high for exactly
// one cycle. busy stays high through that cycle as well, so a new item can be
// taken only once done_o has fallen again. The receiver cannot
// stall the result. The key registers sit at byte addresses 0 and 8 of the
// 64-bit APB port and should be written only while busy is low.
module aes128_milenage_f1_mac (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] challenge_high_i,
  input  wire logic [63:0] challenge_low_i,
  input  wire logic [63:0] second_high_i,
  input  wire logic [63:0] second_low_i,
  output logic             done_o,
  output logic      [63:0] mac_o
);

  localparam logic [3:0] AddrKeyHigh = 4'h0;
  localparam logic [3:0] AddrKeyLow = 4'h8;

  logic [63:0] key_high_q, key_low_q;
  logic [127:0] chal_q, second_q;
  logic [127:0] state_q, state_d;
  logic [127:0] rkey_q, rkey_d;
  logic [127:0] opc_q, opc_d;
  logic [127:0] temp_q, temp_d;
  logic [3:0] round_q, round_d;
  logic [7:0] rcon_q, rcon_d;
  milf1_pkg::state_e st_q, st_d;
  milf1_pkg::phase_e ph_q, ph_d;
  logic [63:0] mac_q, mac_d;
  logic done_q, done_d;
  logic [127:0] key_w, src_w, rot_w, nkey_w, rnd_w;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q <= '0;
    end else if (cfg_wr) begin
      if (paddr == AddrKeyHigh) key_high_q <= pwdata;
      if (paddr == AddrKeyLow) key_low_q <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr)
      AddrKeyHigh: prdata = key_high_q;
      AddrKeyLow:  prdata = key_low_q;
      default:     prdata = '0;
    endcase
  end

  assign key_w = {key_high_q, key_low_q};
  assign rot_w = {second_q[63:0] ^ opc_q[63:0], second_q[127:64] ^ opc_q[127:64]};
  assign nkey_w = milf1_pkg::next_key(rkey_q, rcon_q);
  assign rnd_w = milf1_pkg::aes_round(state_q, round_q == milf1_pkg::LastRound);

  always_comb begin
    case (ph_q)
      milf1_pkg::PH_OPC:  src_w = milf1_pkg::OpConst;
      milf1_pkg::PH_TEMP: src_w = chal_q ^ opc_q;
      default:            src_w = rot_w ^ temp_q;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      milf1_pkg::ST_IDLE:  if (start) st_d = milf1_pkg::ST_LOAD;
      milf1_pkg::ST_LOAD:  st_d = milf1_pkg::ST_ROUND;
      milf1_pkg::ST_ROUND: if (round_q == milf1_pkg::LastRound) st_d = milf1_pkg::ST_NEXT;
      milf1_pkg::ST_NEXT:  st_d = (ph_q == milf1_pkg::PH_OUT) ? milf1_pkg::ST_DONE
                                                              : milf1_pkg::ST_LOAD;
      milf1_pkg::ST_DONE:  st_d = milf1_pkg::ST_IDLE;
      default:             st_d = milf1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    rkey_d = rkey_q;
    round_d = round_q;
    rcon_d = rcon_q;
    opc_d = opc_q;
    temp_d = temp_q;
    ph_d = ph_q;
    mac_d = mac_q;
    done_d = 1'b0;
    unique case (st_q)
      milf1_pkg::ST_IDLE: begin
        ph_d = milf1_pkg::PH_OPC;
      end
      milf1_pkg::ST_LOAD: begin
        state_d = src_w ^ key_w;
        rkey_d = key_w;
        round_d = 4'd1;
        rcon_d = 8'h01;
      end
      milf1_pkg::ST_ROUND: begin
        state_d = rnd_w ^ nkey_w;
        rkey_d = nkey_w;
        rcon_d = milf1_pkg::gf_double(rcon_q);
        round_d = round_q + 4'd1;
      end
      milf1_pkg::ST_NEXT: begin
        case (ph_q)
          milf1_pkg::PH_OPC: begin
            opc_d = state_q ^ milf1_pkg::OpConst;
            ph_d = milf1_pkg::PH_TEMP;
          end
          milf1_pkg::PH_TEMP: begin
            temp_d = state_q;
            ph_d = milf1_pkg::PH_OUT;
          end
          default: begin
            mac_d = state_q[127:64] ^ opc_q[127:64];
            done_d = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= milf1_pkg::ST_IDLE;
      ph_q <= milf1_pkg::PH_OPC;
      round_q <= '0;
      rcon_q <= 8'h01;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      round_q <= round_d;
      rcon_q <= rcon_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q <= rkey_d;
    opc_q <= opc_d;
    temp_q <= temp_d;
    mac_q <= mac_d;
    if (start && !busy) begin
      chal_q <= {challenge_high_i, challenge_low_i};
      second_q <= {second_high_i, second_low_i};
    end
  end

  assign busy = (st_q != milf1_pkg::ST_IDLE);
  assign done_o = done_q;
  assign mac_o = mac_q;

  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "Start did not raise busy.")
  `ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy, "Busy held after the result.")
  `ASSERT_CLK(a_round_range, clk_i, rst_ni,
    st_q != milf1_pkg::ST_ROUND || (round_q != 4'd0 && round_q <= milf1_pkg::LastRound),
    "Round counter out of range.")
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "Done held longer than one cycle.")

endmodule
`default_nettype wire

FILE: tb/tb_aes128_milenage_f1_mac.sv
// Self-checking testbench of the f1 MAC block with its own AES-128 MAC predictor.
`timescale 1ns / 1ps
module tb_aes128_milenage_f1_mac;

  localparam logic [127:0] OpBlock = 128'h63bfa50ee6523365ff14c1f45f88737d;
  localparam logic [3:0] AddrKeyHigh = 4'd0;
  localparam logic [3:0] AddrKeyLow = 4'd8;
  localparam int TailCycles = 40;
  localparam int StallLimit = 2000;
  localparam int NumRows = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [63:0] challenge_high_i = '0;
  logic [63:0] challenge_low_i = '0;
  logic [63:0] second_high_i = '0;
  logic [63:0] second_low_i = '0;
  logic done_o;
  logic [63:0] mac_o;

  logic [7:0] sub_tab [256];
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  logic [63:0] mac_queue [$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  typedef struct packed {
    logic [63:0] ch_hi;
    logic [63:0] ch_lo;
    logic [63:0] sec_hi;
    logic [63:0] sec_lo;
  } item_t;

  item_t rows [NumRows];

  aes128_milenage_f1_mac u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .challenge_high_i(challenge_high_i), .challenge_low_i(challenge_low_i),
    .second_high_i(second_high_i), .second_low_i(second_low_i),
    .done_o(done_o), .mac_o(mac_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p, x;
    p = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  // The S-box is built from the field inverse and the affine map.
  task automatic build_sub_tab();
    logic [7:0] inv;
    for (int v = 0; v < 256; v++) begin
      inv = '0;
      for (int w = 1; w < 256; w++) begin
        if (gmul(v[7:0], w[7:0]) == 8'h01) inv = w[7:0];
      end
      sub_tab[v] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                   ^ 8'h63;
    end
  endtask

  function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
    byte_at = b[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] aes128_encrypt(input logic [127:0] blk,
                                                  input logic [127:0] key);
    logic [127:0] rk, st, nx;
    logic [7:0] rc, a0, a1, a2, a3, al;
    logic [7:0] t [16];
    rk = key;
    st = blk ^ rk;
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 4; i++) begin
          t[c * 4 + i] = sub_tab[byte_at(st, ((c + i) % 4) * 4 + i)];
        end
      end
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c * 4];
          a1 = t[c * 4 + 1];
          a2 = t[c * 4 + 2];
          a3 = t[c * 4 + 3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c * 4] = a0 ^ al ^ xtime(a0 ^ a1);
          t[c * 4 + 1] = a1 ^ al ^ xtime(a1 ^ a2);
          t[c * 4 + 2] = a2 ^ al ^ xtime(a2 ^ a3);
          t[c * 4 + 3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
      end
      nx[127:96] = rk[127:96] ^ {sub_tab[byte_at(rk, 13)] ^ rc, sub_tab[byte_at(rk, 14)],
                                 sub_tab[byte_at(rk, 15)], sub_tab[byte_at(rk, 12)]};
      nx[95:64] = rk[95:64] ^ nx[127:96];
      nx[63:32] = rk[63:32] ^ nx[95:64];
      nx[31:0] = rk[31:0] ^ nx[63:32];
      rk = nx;
      rc = xtime(rc);
      for (int i = 0; i < 16; i++) begin
        st[127 - 8 * i -: 8] = t[i] ^ byte_at(rk, i);
      end
    end
    aes128_encrypt = st;
  endfunction

  function automatic logic [63:0] f1_mac(input item_t it, input logic [127:0] key);
    logic [127:0] opc, temp, x, blk, outb;
    opc = aes128_encrypt(OpBlock, key) ^ OpBlock;
    temp = aes128_encrypt({it.ch_hi, it.ch_lo} ^ opc, key);
    x = {it.sec_hi, it.sec_lo} ^ opc;
    blk = {x[63:0], x[127:64]} ^ temp;
    outb = aes128_encrypt(blk, key);
    f1_mac = outb[127:64] ^ opc[127:64];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        mac_queue.push_back(f1_mac({challenge_high_i, challenge_low_i, second_high_i,
                                    second_low_i}, {key_hi_q, key_lo_q}));
      end
      if (done_o) begin
        if (mac_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected MAC %h", mac_o);
        end else begin
          if (mac_o !== mac_queue[0]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("MAC mismatch: expected %h, got %h", mac_queue[0], mac_o);
            end
          end
          void'(mac_queue.pop_front());
        end
      end
      if ((start && !busy) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == AddrKeyHigh) key_hi_q = value;
    else key_lo_q = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Key readback at %0d: expected %h, got %h", addr, value, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_results();
    while (mac_queue.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    drain_results();
    write_key(AddrKeyHigh, hi);
    write_key(AddrKeyLow, lo);
  endtask

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    challenge_high_i <= it.ch_hi;
    challenge_low_i <= it.ch_lo;
    second_high_i <= it.sec_hi;
    second_low_i <= it.sec_lo;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic item_t random_item();
    random_item = {$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] khi, klo;
    rows[0] = '0;
    rows[1] = '1;
    rows[2] = {{4{64'haaaaaaaaaaaaaaaa}}};
    rows[3] = {{4{64'h5555555555555555}}};
    rows[4] = {64'h8000000000000000, 64'h0, 64'h0, 64'h1};
    rows[5] = {64'h0, 64'h1, 64'h8000000000000000, 64'h0};
    rows[6] = {64'hffffffffffffffff, 64'h0, 64'h0, 64'hffffffffffffffff};
    rows[7] = {OpBlock, OpBlock};
    rows[8] = {64'h0123456789abcdef, 64'hfedcba9876543210, 64'h0, 64'h0};
    rows[9] = {64'h0, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210};
    build_sub_tab();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run first with the reset key, then with an all-ones key.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        start <= 1'b0;
        set_key('1, '1);
      end
      for (int r = 0; r < NumRows; r++) send_item(rows[r]);
    end

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 30 : (mode == 1) ? 73 : 0;
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin
            khi = (mode == 1) ? '1 : '0;
            klo = (mode == 1) ? '0 : '1;
          end
          1: begin
            khi = '0;
            klo = '0;
          end
          default: begin
            khi = {$urandom, $urandom};
            klo = {$urandom, $urandom};
          end
        endcase
        start <= 1'b0;
        set_key(khi, klo);
        for (int n = 0; n < 130; n++) send_item(random_item());
      end
    end
    start <= 1'b0;
    drain_results();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
